FILE: hw/rtl/zsrd_pkg.sv
`default_nettype none
package zsrd_pkg;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_CENTER = 2'd0,
    OP_LEFT   = 2'd1,
    OP_RIGHT  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Scan phase
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_LEFT  = 2'd1,
    PH_RIGHT = 2'd2
  } phase_t;

  localparam logic [5:0] SAT6           = 6'd63;
  localparam logic [5:0] RUN_LEN_LIMIT  = 6'd20;
  localparam logic [5:0] RUN_DIFF_LIMIT = 6'd10;
  localparam logic [5:0] CHECKED_RUNS   = 6'd5;
  localparam logic [5:0] MIN_RUNS       = CHECKED_RUNS + 6'd2;
  localparam logic [7:0] THRESHOLD_RST  = 8'd128;

  // Per-side run tracking state
  typedef struct packed {
    logic [5:0] run_index;
    logic [5:0] cur_len;
    logic [5:0] prev_len;
    logic       ok;
    logic [5:0] span;
  } side_t;

  // One result transaction
  typedef struct packed {
    logic       left_is_zebra;
    logic       right_is_zebra;
    logic       is_zebra;
    logic       zebra_seen;
    logic [5:0] left_run_count;
    logic [5:0] right_run_count;
  } result_t;

  localparam side_t SIDE_CLEAR = '{
    run_index: 6'd0, cur_len: 6'd0, prev_len: 6'd0, ok: 1'b1, span: 6'd0
  };

  function automatic logic side_verdict(input side_t s);
    return s.ok && (s.run_index >= MIN_RUNS);
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/zsrd_in_reg.sv
`default_nettype none
module zsrd_in_reg
  import zsrd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_op,
  input  wire logic [7:0] in_pixel,
  input  wire logic       in_end_of_scan,
  input  wire logic       take,
  output logic            s1_valid,
  output logic [1:0]      s1_op,
  output logic [7:0]      s1_pixel,
  output logic            s1_last
);

  logic       valid_r;
  logic [1:0] op_r;
  logic [7:0] pixel_r;
  logic       last_r;

  // Accept when empty or when the held transaction moves on
  assign in_ready = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Capture payload on acceptance
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r    <= in_op;
      pixel_r <= in_pixel;
      last_r  <= in_end_of_scan;
    end
  end

  assign s1_valid = valid_r;
  assign s1_op    = op_r;
  assign s1_pixel = pixel_r;
  assign s1_last  = last_r;

endmodule
`default_nettype wire

FILE: hw/rtl/zsrd_run_step.sv
`default_nettype none
module zsrd_run_step
  import zsrd_pkg::*;
(
  input  wire side_t       side_in,
  input  wire logic        center_bright,
  input  wire logic [7:0]  threshold,
  input  wire logic [7:0]  pixel,
  input  wire logic [5:0]  span_lim,
  output side_t            side_out
);

  logic       bright;
  logic       expect_bright;
  logic [5:0] diff;

  assign bright        = pixel > threshold;
  assign expect_bright = ~center_bright ^ side_in.run_index[0];
  assign diff = (side_in.cur_len > side_in.prev_len) ?
                (side_in.cur_len - side_in.prev_len) :
                (side_in.prev_len - side_in.cur_len);

  // Update runs for one pixel
  always_comb begin
    side_out = side_in;
    if (side_in.span < span_lim) begin
      side_out.span = side_in.span + 6'd1;
      if (pixel != threshold) begin
        if ((bright == expect_bright) || (side_in.run_index >= SAT6)) begin
          // lengthen the current run
          if (side_in.cur_len < SAT6) begin
            side_out.cur_len = side_in.cur_len + 6'd1;
          end
        end else begin
          // close the current run, check it against the previous one
          if ((side_in.run_index >= 6'd2) && (side_in.run_index <= CHECKED_RUNS + 6'd1)) begin
            if (!((side_in.prev_len >= 6'd1) && (side_in.prev_len < RUN_LEN_LIMIT) &&
                  (diff < RUN_DIFF_LIMIT))) begin
              side_out.ok = 1'b0;
            end
          end
          side_out.prev_len  = side_in.cur_len;
          side_out.run_index = side_in.run_index + 6'd1;
          side_out.cur_len   = 6'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/zsrd_out_reg.sv
`default_nettype none
module zsrd_out_reg
  import zsrd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire result_t res_in,
  output logic         free,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      res_out
);

  logic    valid_r;
  result_t res_r;

  assign free = !valid_r || out_ready;

  // Hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule
`default_nettype wire

FILE: hw/rtl/zebra_stripe_run_detector_top.sv
`default_nettype none
// A result moves from the input register into the result register once the
// transaction that ends the scan is accepted and the result register is free.
// Throughput: one transaction per cycle, set by the combinational run update;
// the input stalls only while the result register holds an unaccepted result.
// Reset (rst_n, synchronous, active low): threshold 128, scan idle, side state
// cleared, sticky flag cleared, both channel registers empty.
module zebra_stripe_run_detector_top
  import zsrd_pkg::*;
#(
  parameter int MAX_SPAN = 50
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_op,
  input  wire logic [7:0] in_pixel,
  input  wire logic       in_end_of_scan,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_left_is_zebra,
  output logic            out_right_is_zebra,
  output logic            out_is_zebra,
  output logic            out_zebra_seen,
  output logic [5:0]      out_left_run_count,
  output logic [5:0]      out_right_run_count,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  localparam int SPAN_LIM_I = (MAX_SPAN > 63) ? 63 : MAX_SPAN;
  localparam logic [5:0] SPAN_LIM = 6'(SPAN_LIM_I);

  logic       s1_valid;
  logic [1:0] s1_op_raw;
  op_t        s1_op;
  logic [7:0] s1_pixel;
  logic       s1_last;
  logic       out_free;
  logic       fire;

  logic [7:0] threshold_r;
  logic       center_bright_r, center_bright_nxt;
  side_t      side_r, side_nxt;
  logic       left_verdict_r, left_verdict_nxt;
  logic [5:0] left_runs_r, left_runs_nxt;
  logic       sticky_r, sticky_nxt;
  phase_t     phase_r, phase_nxt, phase_mid;

  side_t      step_in, step_out, side_mid;
  logic       active;
  logic       res_load;
  result_t    res;
  result_t    res_q;
  logic       rv;

  zsrd_in_reg u_in (
    .clk, .rst_n, .in_valid, .in_ready, .in_op, .in_pixel, .in_end_of_scan,
    .take(fire), .s1_valid, .s1_op(s1_op_raw), .s1_pixel, .s1_last
  );

  assign s1_op = op_t'(s1_op_raw);
  assign fire  = s1_valid && out_free;

  // Side switch: first right pixel of the scan starts from a cleared side
  assign step_in = (s1_op == OP_RIGHT && phase_r == PH_LEFT) ? SIDE_CLEAR : side_r;

  zsrd_run_step u_step (
    .side_in(step_in), .center_bright(center_bright_r), .threshold(threshold_r),
    .pixel(s1_pixel), .span_lim(SPAN_LIM), .side_out(step_out)
  );

  // Transaction counts at all: not the unused op, not a pixel with no scan open
  assign active = (s1_op == OP_CENTER) ||
                  ((s1_op == OP_LEFT || s1_op == OP_RIGHT) && phase_r != PH_IDLE);

  // Phase after the pixel, before the end-of-scan handling
  always_comb begin
    phase_mid = phase_r;
    unique case (s1_op)
      OP_CENTER: phase_mid = PH_LEFT;
      OP_RIGHT:  if (phase_r != PH_IDLE) phase_mid = PH_RIGHT;
      default:   phase_mid = phase_r;
    endcase
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (fire && active) begin
      phase_nxt = s1_last ? PH_IDLE : phase_mid;
    end
  end

  // Side state, left latch and result
  always_comb begin
    center_bright_nxt = center_bright_r;
    left_verdict_nxt  = left_verdict_r;
    left_runs_nxt     = left_runs_r;
    sticky_nxt        = sticky_r;
    side_mid          = side_r;
    side_nxt          = side_r;
    res_load          = 1'b0;
    rv                = 1'b0;

    unique case (s1_op)
      OP_CENTER: begin
        center_bright_nxt = s1_pixel > threshold_r;
        side_mid          = SIDE_CLEAR;
      end
      OP_LEFT: begin
        if (phase_r == PH_LEFT) side_mid = step_out;
      end
      OP_RIGHT: begin
        if (phase_r == PH_LEFT) begin
          left_verdict_nxt = side_verdict(side_r);
          left_runs_nxt    = side_r.run_index;
        end
        if (phase_r != PH_IDLE) side_mid = step_out;
      end
      default: side_mid = side_r;
    endcase

    side_nxt = side_mid;
    if (s1_last) begin
      // end on the left side latches it and leaves an empty right side
      if (phase_mid == PH_LEFT) begin
        left_verdict_nxt = side_verdict(side_mid);
        left_runs_nxt    = side_mid.run_index;
        side_nxt         = SIDE_CLEAR;
      end
      rv         = side_verdict(side_nxt);
      sticky_nxt = sticky_r | (left_verdict_nxt & rv);
      res_load   = active;
    end

    res.left_is_zebra   = left_verdict_nxt;
    res.right_is_zebra  = rv;
    res.is_zebra        = left_verdict_nxt & rv;
    res.zebra_seen      = sticky_nxt;
    res.left_run_count  = left_runs_nxt;
    res.right_run_count = side_nxt.run_index;
  end

  // Commit state on each consumed active transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r     <= THRESHOLD_RST;
      center_bright_r <= 1'b0;
      side_r          <= SIDE_CLEAR;
      left_verdict_r  <= 1'b0;
      left_runs_r     <= 6'd0;
      sticky_r        <= 1'b0;
      phase_r         <= PH_IDLE;
    end else begin
      if (cfg_we) threshold_r <= cfg_wdata;
      phase_r <= phase_nxt;
      if (fire && active) begin
        center_bright_r <= center_bright_nxt;
        side_r          <= side_nxt;
        left_verdict_r  <= left_verdict_nxt;
        left_runs_r     <= left_runs_nxt;
        sticky_r        <= sticky_nxt;
      end
    end
  end

  zsrd_out_reg u_out (
    .clk, .rst_n, .load(fire && res_load), .res_in(res), .free(out_free),
    .out_valid, .out_ready, .res_out(res_q)
  );

  assign out_left_is_zebra   = res_q.left_is_zebra;
  assign out_right_is_zebra  = res_q.right_is_zebra;
  assign out_is_zebra        = res_q.is_zebra;
  assign out_zebra_seen      = res_q.zebra_seen;
  assign out_left_run_count  = res_q.left_run_count;
  assign out_right_run_count = res_q.right_run_count;

endmodule
`default_nettype wire

FILE: bench/zebra_stripe_run_detector_top_tb.sv
`timescale 1ns / 1ps

module zebra_stripe_run_detector_top_tb;
  import zsrd_pkg::*;

  localparam int MAX_SPAN = 50;
  localparam int SPAN_CAP = (MAX_SPAN > 63) ? 63 : MAX_SPAN;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 60;
  localparam int PHASE_ITEMS = 45;
  localparam int PHASE_VERDICTS = 1;

  // One input transaction as the stimulus sees it
  typedef struct packed {
    op_t        op;
    logic [7:0] pixel;
    logic       eos;
  } px_item_t;

  // Directed row: optional typed-in verdict where it is obvious
  typedef struct packed {
    op_t        op;
    logic [7:0] pixel;
    logic       eos;
    bit         typed;
    result_t    res;
  } dir_row_t;

  localparam result_t R_EMPTY = '0;
  localparam result_t R_LEFT1 = '{1'b0, 1'b0, 1'b0, 1'b0, 6'd1, 6'd0};

  // Threshold stays at its reset value of 128 throughout this table
  localparam dir_row_t DIR_ROWS [20] = '{
    '{OP_CENTER, 8'd0,   1'b1, 1'b1, R_EMPTY},  // scan that ends on its center pixel
    '{OP_LEFT,   8'd255, 1'b1, 1'b0, '0},       // no scan open: dropped
    '{OP_RIGHT,  8'd0,   1'b1, 1'b0, '0},       // no scan open: dropped
    '{OP_NONE,   8'd255, 1'b1, 1'b0, '0},       // unused op
    '{OP_CENTER, 8'd255, 1'b0, 1'b0, '0},       // bright center
    '{OP_CENTER, 8'd128, 1'b0, 1'b0, '0},       // restart, center at threshold is dark
    '{OP_LEFT,   8'd128, 1'b0, 1'b0, '0},       // pixel at threshold
    '{OP_LEFT,   8'd255, 1'b0, 1'b0, '0},
    '{OP_LEFT,   8'd0,   1'b0, 1'b0, '0},
    '{OP_LEFT,   8'd129, 1'b0, 1'b0, '0},
    '{OP_LEFT,   8'd127, 1'b0, 1'b0, '0},
    '{OP_RIGHT,  8'd127, 1'b0, 1'b0, '0},       // side switch
    '{OP_LEFT,   8'd255, 1'b0, 1'b0, '0},       // left after right: ignored
    '{OP_NONE,   8'd0,   1'b0, 1'b0, '0},
    '{OP_RIGHT,  8'd200, 1'b0, 1'b0, '0},
    '{OP_LEFT,   8'd0,   1'b1, 1'b0, '0},       // left after right still ends the scan
    '{OP_CENTER, 8'd0,   1'b0, 1'b0, '0},
    '{OP_LEFT,   8'd0,   1'b1, 1'b1, R_LEFT1},  // end on the left side
    '{OP_CENTER, 8'd0,   1'b0, 1'b0, '0},
    '{OP_RIGHT,  8'd255, 1'b1, 1'b1, R_EMPTY}   // empty left side
  };

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_op;
  logic [7:0] in_pixel;
  logic       in_end_of_scan;
  logic       out_valid;
  logic       out_ready;
  logic       out_left_is_zebra;
  logic       out_right_is_zebra;
  logic       out_is_zebra;
  logic       out_zebra_seen;
  logic [5:0] out_left_run_count;
  logic [5:0] out_right_run_count;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  // Predictor state
  logic [7:0] thr_model = THRESHOLD_RST;
  logic       center_bright = 1'b0;
  side_t      side_st = SIDE_CLEAR;
  phase_t     scan_phase = PH_IDLE;
  logic       left_ok = 1'b0;
  logic [5:0] left_runs = 6'd0;
  logic       seen_model = 1'b0;

  result_t    pending_verdicts [$];
  px_item_t   scan_items [$];
  logic       gen_bright;
  int         err_count = 0;
  int         items_sent = 0;
  int         verdicts_sent = 0;
  int         cycles = 0;
  int         idle_pct = 0;
  bit         hold_long = 1'b0;

  zebra_stripe_run_detector_top #(.MAX_SPAN(MAX_SPAN)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_pixel           (in_pixel),
    .in_end_of_scan     (in_end_of_scan),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_left_is_zebra  (out_left_is_zebra),
    .out_right_is_zebra (out_right_is_zebra),
    .out_is_zebra       (out_is_zebra),
    .out_zebra_seen     (out_zebra_seen),
    .out_left_run_count (out_left_run_count),
    .out_right_run_count(out_right_run_count),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Side verdict: enough runs and no bad run pair seen
  function automatic logic side_is_stripe(input side_t s);
    return s.ok && (s.run_index >= MIN_RUNS);
  endfunction

  // Advance the run tracker of the open side by one pixel
  task automatic absorb_pixel(input logic [7:0] pix);
    logic bright;
    logic want;
    int   diff;
    if (side_st.span >= SPAN_CAP) return;
    side_st.span = side_st.span + 6'd1;
    if (pix == thr_model) return;
    bright = pix > thr_model;
    want = ~center_bright ^ side_st.run_index[0];
    if (bright == want || side_st.run_index >= SAT6) begin
      if (side_st.cur_len < SAT6) side_st.cur_len = side_st.cur_len + 6'd1;
      return;
    end
    // run closes: check it against the one before
    if (side_st.run_index >= 2 && int'(side_st.run_index) <= int'(CHECKED_RUNS) + 1) begin
      diff = int'(side_st.cur_len) - int'(side_st.prev_len);
      if (diff < 0) diff = -diff;
      if (!(side_st.prev_len >= 1 && side_st.prev_len < RUN_LEN_LIMIT &&
            diff < int'(RUN_DIFF_LIMIT)))
        side_st.ok = 1'b0;
    end
    side_st.prev_len = side_st.cur_len;
    side_st.run_index = side_st.run_index + 6'd1;
    side_st.cur_len = 6'd1;
  endtask

  task automatic close_left_side();
    left_ok = side_is_stripe(side_st);
    left_runs = side_st.run_index;
    side_st = SIDE_CLEAR;
    scan_phase = PH_RIGHT;
  endtask

  // Work out the verdict, if any, caused by one accepted transaction
  task automatic predict_verdict(input op_t op, input logic [7:0] pix, input logic eos,
                                 output bit has_res, output result_t res);
    logic right_ok;
    has_res = 1'b0;
    res = '0;
    if (op == OP_NONE) return;
    if (op == OP_CENTER) begin
      center_bright = pix > thr_model;
      side_st = SIDE_CLEAR;
      scan_phase = PH_LEFT;
    end else if (scan_phase == PH_IDLE) begin
      return;
    end else if (op == OP_LEFT) begin
      if (scan_phase == PH_LEFT) absorb_pixel(pix);
    end else begin
      if (scan_phase == PH_LEFT) close_left_side();
      absorb_pixel(pix);
    end
    if (!eos) return;
    if (scan_phase == PH_LEFT) close_left_side();
    right_ok = side_is_stripe(side_st);
    seen_model = seen_model | (left_ok & right_ok);
    res.left_is_zebra = left_ok;
    res.right_is_zebra = right_ok;
    res.is_zebra = left_ok & right_ok;
    res.zebra_seen = seen_model;
    res.left_run_count = left_runs;
    res.right_run_count = side_st.run_index;
    scan_phase = PH_IDLE;
    has_res = 1'b1;
  endtask

  // Offer one transaction, hold it until accepted, then predict
  task automatic send_item(input op_t op, input logic [7:0] pix, input logic eos,
                           input bit typed, input result_t typed_res);
    bit      produced;
    result_t predicted;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_pixel <= pix;
    in_end_of_scan <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    predict_verdict(op, pix, eos, produced, predicted);
    if (produced) begin
      pending_verdicts.push_back(typed ? typed_res : predicted);
      verdicts_sent++;
    end
    @(negedge clk);
  endtask

  function automatic logic [7:0] class_pixel(input bit bright);
    int t;
    t = thr_model;
    if (bright) return (t == 255) ? 8'(t) : 8'($urandom_range(255, t + 1));
    return (t == 0) ? 8'(t) : 8'($urandom_range(t - 1, 0));
  endfunction

  // Mostly clean stripe pixels, sometimes at threshold or arbitrary
  function automatic logic [7:0] noisy_pixel(input bit bright);
    int r;
    r = $urandom_range(0, 29);
    if (r == 0) return thr_model;
    if (r == 1) return 8'($urandom_range(0, 255));
    return class_pixel(bright);
  endfunction

  // Queue one side of stripes, run 0 may be empty
  task automatic queue_side(input op_t side_op, input int n_runs, input int len_hi);
    int len;
    for (int k = 0; k < n_runs; k++) begin
      len = (k == 0) ? $urandom_range(0, 3) : $urandom_range(1, len_hi);
      if ($urandom_range(0, 9) == 0) len = $urandom_range(10, 24);
      for (int j = 0; j < len; j++) begin
        scan_items.push_back('{side_op, noisy_pixel(~gen_bright ^ k[0]), 1'b0});
        if (side_op == OP_RIGHT && $urandom_range(0, 19) == 0)
          scan_items.push_back('{OP_LEFT, 8'($urandom_range(0, 255)), 1'b0});
        if ($urandom_range(0, 39) == 0)
          scan_items.push_back('{OP_NONE, 8'($urandom_range(0, 255)), 1'b0});
      end
    end
  endtask

  // Build one scan of the given flavor and send it
  task automatic run_scan(input int kind);
    bit closes;
    closes = 1'b1;
    scan_items.delete();
    gen_bright = $urandom_range(0, 1);
    scan_items.push_back('{OP_CENTER,
                           ($urandom_range(0, 15) == 0) ? thr_model : class_pixel(gen_bright),
                           1'b0});
    case (kind)
      5: begin
        // end on the center pixel
      end
      6: begin
        queue_side(OP_LEFT, $urandom_range(1, 9), 6);
      end
      7: begin
        // abandoned: the next center pixel restarts
        queue_side(OP_LEFT, $urandom_range(1, 4), 4);
        closes = 1'b0;
      end
      8: begin
        // long runs that run past the span limit
        queue_side(OP_LEFT, $urandom_range(4, 9), 15);
        queue_side(OP_RIGHT, $urandom_range(4, 9), 15);
      end
      9: begin
        scan_items.delete();
        repeat ($urandom_range(2, 8))
          scan_items.push_back('{op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 3) == 0)});
        closes = 1'b0;
      end
      default: begin
        queue_side(OP_LEFT, $urandom_range(3, 10), 6);
        queue_side(OP_RIGHT, $urandom_range(3, 10), 6);
      end
    endcase
    if (closes) scan_items[scan_items.size() - 1].eos = 1'b1;
    foreach (scan_items[i])
      send_item(scan_items[i].op, scan_items[i].pixel, scan_items[i].eos, 1'b0, '0);
  endtask

  // Drain the block before touching the register
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    thr_model = value;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  // Compare each accepted result transaction with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("result transaction with no verdict pending");
        err_count++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("left_is_zebra", want.left_is_zebra, out_left_is_zebra);
        check_field("right_is_zebra", want.right_is_zebra, out_right_is_zebra);
        check_field("is_zebra", want.is_zebra, out_is_zebra);
        check_field("zebra_seen", want.zebra_seen, out_zebra_seen);
        check_field("left_run_count", want.left_run_count, out_left_run_count);
        check_field("right_run_count", want.right_run_count, out_right_run_count);
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold on request
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_long = 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Sender and run control
  initial begin
    int items_mark;
    int verdicts_mark;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_CENTER;
    in_pixel = 8'd0;
    in_end_of_scan = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 8'd0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    idle_pct = 20;
    foreach (DIR_ROWS[i])
      send_item(DIR_ROWS[i].op, DIR_ROWS[i].pixel, DIR_ROWS[i].eos,
                DIR_ROWS[i].typed, DIR_ROWS[i].res);

    // Threshold phases: reset value, both extremes, random, then back to mid
    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        1: write_threshold(8'd0);
        2: write_threshold(8'd255);
        3, 4: write_threshold(8'($urandom_range(40, 215)));
        5: write_threshold(THRESHOLD_RST);
        default: ;
      endcase
      idle_pct = (p == 5) ? 0 : 10 * $urandom_range(0, 4);
      if (p == 3) begin
        // stall the receiver while short scans pile up behind it
        hold_long = 1'b1;
        repeat (12) run_scan(5);
      end
      items_mark = items_sent;
      verdicts_mark = verdicts_sent;
      while (items_sent - items_mark < PHASE_ITEMS ||
             verdicts_sent - verdicts_mark < PHASE_VERDICTS)
        run_scan($urandom_range(0, 9));
    end

    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/zsrd_pkg.sv
hw/rtl/zsrd_in_reg.sv
hw/rtl/zsrd_run_step.sv
hw/rtl/zsrd_out_reg.sv
hw/rtl/zebra_stripe_run_detector_top.sv
bench/zebra_stripe_run_detector_top_tb.sv
